// ===== hdl/bucketed_hash_table_with_aging_macros.svh =====
// ---------------------------------------------------------------------------
// bucketed_hash_table_with_aging_macros.svh
// Assertion macros shared by the hash table RTL.
// ---------------------------------------------------------------------------
`ifndef BUCKETED_HASH_TABLE_WITH_AGING_MACROS_SVH
`define BUCKETED_HASH_TABLE_WITH_AGING_MACROS_SVH

// same-cycle implication, disabled during reset
`define BHTA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BHTA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bhta_pkg.sv =====
// ---------------------------------------------------------------------------
// bhta_pkg
// Types and constants of the bucketed hash table with generation aging.
// ---------------------------------------------------------------------------
package bhta_pkg;

    localparam int INDEX_BITS  = 16;
    localparam int WAY_BITS    = 2;   // bucket of 2^WAY_BITS slots, WAY_BITS <= INDEX_BITS
    localparam int BUCKET_WAYS = 1 << WAY_BITS;
    localparam int ROW_BITS    = INDEX_BITS - WAY_BITS;
    localparam int ROW_COUNT   = 1 << ROW_BITS;
    localparam int KEY_BITS    = 64;
    localparam int TAG_SHIFT   = 32;
    localparam int TAG_BITS    = KEY_BITS - TAG_SHIFT;
    localparam int SCORE_BITS  = 16;
    localparam int DEPTH_BITS  = 8;
    localparam int FLAG_BITS   = 2;
    localparam int GEN_BITS    = 8;
    localparam int MOVE_BITS   = 16;
    localparam int AGE_PENALTY = 1000;
    // depth range less the age penalty fits in 12 bits signed
    localparam int PRIO_BITS   = 12;

    localparam logic [FLAG_BITS-1:0] FLAG_EMPTY = 2'd0;

    typedef enum logic
    {
        OP_PROBE = 1'b0,
        OP_STORE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } state_t;

    typedef struct packed
    {
        logic [TAG_BITS-1:0]          tag;
        logic signed [DEPTH_BITS-1:0] depth;
        logic [FLAG_BITS-1:0]         flag;
        logic [GEN_BITS-1:0]          gen;
    } tag_word_t;

    typedef struct packed
    {
        logic signed [SCORE_BITS-1:0] score;
        logic [MOVE_BITS-1:0]         move;
    } payload_t;

    typedef tag_word_t [BUCKET_WAYS-1:0] tag_row_t;
    typedef payload_t  [BUCKET_WAYS-1:0] pay_row_t;

    typedef struct packed
    {
        logic                en;
        logic                clr;   // whole row to zero
        logic [ROW_BITS-1:0] row;
        logic [WAY_BITS-1:0] way;
        tag_word_t           tag;
        payload_t            pay;
    } mem_wr_t;

    typedef struct packed
    {
        logic                         hit;
        logic signed [SCORE_BITS-1:0] score;
        logic signed [DEPTH_BITS-1:0] depth;
        logic [FLAG_BITS-1:0]         flag;
        logic [GEN_BITS-1:0]          gen;
        logic [MOVE_BITS-1:0]         move;
    } probe_res_t;

endpackage

// ===== hdl/bhta_if.sv =====
// ---------------------------------------------------------------------------
// bhta_if
// Request and response channels of the hash table.
// ---------------------------------------------------------------------------
interface bhta_req_if;
    logic                                   valid;
    logic                                   ready;
    bhta_pkg::op_t                          op;
    logic [bhta_pkg::KEY_BITS-1:0]          key;
    logic signed [bhta_pkg::SCORE_BITS-1:0] new_score;
    logic signed [bhta_pkg::DEPTH_BITS-1:0] new_depth;
    logic [bhta_pkg::FLAG_BITS-1:0]         new_flag;
    logic [bhta_pkg::MOVE_BITS-1:0]         new_move;

    modport source (output valid, op, key, new_score, new_depth, new_flag, new_move,
                    input ready);
    modport sink   (input valid, op, key, new_score, new_depth, new_flag, new_move,
                    output ready);
endinterface

interface bhta_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   hit;
    logic signed [bhta_pkg::SCORE_BITS-1:0] found_score;
    logic signed [bhta_pkg::DEPTH_BITS-1:0] found_depth;
    logic [bhta_pkg::FLAG_BITS-1:0]         found_flag;
    logic [bhta_pkg::GEN_BITS-1:0]          found_generation;
    logic [bhta_pkg::MOVE_BITS-1:0]         found_move;

    modport source (output valid, hit, found_score, found_depth, found_flag,
                    found_generation, found_move,
                    input ready);
    modport sink   (input valid, hit, found_score, found_depth, found_flag,
                    found_generation, found_move,
                    output ready);
endinterface

// ===== hdl/bhta_bucket_mem.sv =====
// ---------------------------------------------------------------------------
// bhta_bucket_mem
// Bucket-wide tag and payload memories: one row read, one slot or row written.
// ---------------------------------------------------------------------------
module bhta_bucket_mem
(
    input  logic                            clk,
    input  logic                            rd_en,
    input  logic [bhta_pkg::ROW_BITS-1:0]   rd_row,
    input  bhta_pkg::mem_wr_t               wr,
    output bhta_pkg::tag_row_t              rd_tag,
    output bhta_pkg::pay_row_t              rd_pay
);

    bhta_pkg::tag_row_t tag_mem [bhta_pkg::ROW_COUNT];
    bhta_pkg::pay_row_t pay_mem [bhta_pkg::ROW_COUNT];

    bhta_pkg::tag_row_t rd_tag_reg;
    bhta_pkg::pay_row_t rd_pay_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            if (wr.clr)
            begin
                tag_mem[wr.row] <= '0;
                pay_mem[wr.row] <= '0;
            end
            else
            begin
                tag_mem[wr.row][wr.way] <= wr.tag;
                pay_mem[wr.row][wr.way] <= wr.pay;
            end
        end
    end

    // read data held while not enabled, so a stalled probe keeps its row
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_tag_reg <= tag_mem[rd_row];
            rd_pay_reg <= pay_mem[rd_row];
        end
    end

    assign rd_tag = rd_tag_reg;
    assign rd_pay = rd_pay_reg;

endmodule

// ===== hdl/bhta_way_select.sv =====
// ---------------------------------------------------------------------------
// bhta_way_select
// Scans one bucket row: first valid tag hit, and victim slot for a store.
// ---------------------------------------------------------------------------
module bhta_way_select
(
    input  bhta_pkg::tag_row_t              tag_row,
    input  bhta_pkg::pay_row_t              pay_row,
    input  logic [bhta_pkg::WAY_BITS-1:0]   home_way,
    input  logic [bhta_pkg::TAG_BITS-1:0]   tag,
    input  logic [bhta_pkg::GEN_BITS-1:0]   cur_gen,
    output bhta_pkg::probe_res_t            res,
    output logic [bhta_pkg::WAY_BITS-1:0]   victim
);

    logic [bhta_pkg::WAY_BITS:0]            w;
    logic [bhta_pkg::WAY_BITS-1:0]          slot;
    logic                                   found;
    logic                                   tag_hit;
    logic                                   have_best;
    logic signed [bhta_pkg::PRIO_BITS-1:0]  prio;
    logic signed [bhta_pkg::PRIO_BITS-1:0]  lowest;

    // ways visited in order home ^ 0, home ^ 1, ...
    always_comb
    begin
        res       = '0;
        victim    = home_way;
        found     = 1'b0;
        tag_hit   = 1'b0;
        have_best = 1'b0;
        lowest    = '0;
        prio      = '0;
        slot      = '0;
        for (w = '0; w < (bhta_pkg::WAY_BITS+1)'(bhta_pkg::BUCKET_WAYS); w = w + 1'b1)
        begin
            slot = home_way ^ w[bhta_pkg::WAY_BITS-1:0];
            if (!found && tag_row[slot].tag == tag
                && tag_row[slot].flag != bhta_pkg::FLAG_EMPTY)
            begin
                found     = 1'b1;
                res.hit   = 1'b1;
                res.score = pay_row[slot].score;
                res.depth = tag_row[slot].depth;
                res.flag  = tag_row[slot].flag;
                res.gen   = tag_row[slot].gen;
                res.move  = pay_row[slot].move;
            end
            if (!tag_hit)
            begin
                if (tag_row[slot].tag == tag)
                begin
                    tag_hit = 1'b1;
                    victim  = slot;
                end
                else
                begin
                    prio = {{(bhta_pkg::PRIO_BITS-bhta_pkg::DEPTH_BITS)
                             {tag_row[slot].depth[bhta_pkg::DEPTH_BITS-1]}},
                            tag_row[slot].depth};
                    if (tag_row[slot].gen != cur_gen)
                    begin
                        prio = prio - bhta_pkg::PRIO_BITS'(bhta_pkg::AGE_PENALTY);
                    end
                    // first way seeds the minimum; ties keep the earlier way
                    if (!have_best || prio < lowest)
                    begin
                        have_best = 1'b1;
                        lowest    = prio;
                        victim    = slot;
                    end
                end
            end
        end
    end

endmodule

// ===== hdl/bucketed_hash_table_with_aging.sv =====
// ---------------------------------------------------------------------------
// bucketed_hash_table_with_aging
// Bucketed search-result table with tag probe and aged replacement on store.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake      | content
//  ---------+-----+----------------+------------------------------------------
//  req      | in  | valid / ready  | op, key, new_score/depth/flag/move
//  rsp      | out | valid / ready  | hit, found_score/depth/flag/generation/move
//  cfg      | in  | cfg_we         | cfg_wdata -> current generation
//
//  For a request the bucket row is read, then the slot is chosen and a store
//  writes back one slot. A new request is taken only after the last one is done.
//  After reset a clearing pass zeroes all 16384 bucket rows, one row a cycle;
//  no request is taken during the clearing pass.
//  A probe stays in the busy stage while its response cannot enter the
//  response register; a waiting response does not block the next request.
// ---------------------------------------------------------------------------
`include "bucketed_hash_table_with_aging_macros.svh"

module bucketed_hash_table_with_aging
(
    input  logic                            clk,
    input  logic                            rst_n,
    bhta_req_if.sink                        req,
    bhta_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [bhta_pkg::GEN_BITS-1:0]   cfg_wdata
);

    // control state
    bhta_pkg::state_t                       state_reg;
    bhta_pkg::state_t                       state_next;
    logic [bhta_pkg::ROW_BITS-1:0]          clr_row_reg;
    logic [bhta_pkg::ROW_BITS-1:0]          clr_row_next;
    logic [bhta_pkg::GEN_BITS-1:0]          cur_gen_reg;
    logic                                   rsp_valid_reg;
    logic                                   rsp_valid_next;

    // captured request
    bhta_pkg::op_t                          op_reg;
    logic [bhta_pkg::ROW_BITS-1:0]          row_reg;
    logic [bhta_pkg::WAY_BITS-1:0]          home_way_reg;
    logic [bhta_pkg::TAG_BITS-1:0]          tag_reg;
    logic signed [bhta_pkg::SCORE_BITS-1:0] score_reg;
    logic signed [bhta_pkg::DEPTH_BITS-1:0] depth_reg;
    logic [bhta_pkg::FLAG_BITS-1:0]         flag_reg;
    logic [bhta_pkg::MOVE_BITS-1:0]         move_reg;

    bhta_pkg::probe_res_t                   rsp_res_reg;

    // datapath
    logic                                   req_ready;
    logic                                   accept;
    logic                                   rd_en;
    logic                                   done;
    logic                                   probe_done;
    logic                                   clr_last;
    bhta_pkg::mem_wr_t                      mem_wr;
    bhta_pkg::tag_row_t                     rd_tag;
    bhta_pkg::pay_row_t                     rd_pay;
    bhta_pkg::probe_res_t                   sel_res;
    logic [bhta_pkg::WAY_BITS-1:0]          victim;

    assign accept     = req.valid && req_ready;
    assign clr_last   = &clr_row_reg;
    assign probe_done = (state_reg == bhta_pkg::ST_BUSY)
                        && (op_reg == bhta_pkg::OP_PROBE) && done;

    // bucket row of the incoming key; the slot ways are the low index bits
    bhta_bucket_mem u_mem
    (
        .clk    (clk),
        .rd_en  (rd_en),
        .rd_row (req.key[bhta_pkg::INDEX_BITS-1:bhta_pkg::WAY_BITS]),
        .wr     (mem_wr),
        .rd_tag (rd_tag),
        .rd_pay (rd_pay)
    );

    bhta_way_select u_sel
    (
        .tag_row  (rd_tag),
        .pay_row  (rd_pay),
        .home_way (home_way_reg),
        .tag      (tag_reg),
        .cur_gen  (cur_gen_reg),
        .res      (sel_res),
        .victim   (victim)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bhta_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = bhta_pkg::ST_IDLE;
                end
            end
            bhta_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bhta_pkg::ST_BUSY;
                end
            end
            bhta_pkg::ST_BUSY:
            begin
                if (done)
                begin
                    state_next = bhta_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bhta_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs: clearing sweep, read issue, write-back
    always_comb
    begin
        req_ready    = 1'b0;
        rd_en        = 1'b0;
        done         = 1'b0;
        mem_wr       = '0;
        clr_row_next = clr_row_reg;
        case (state_reg)
            bhta_pkg::ST_CLEAR:
            begin
                mem_wr.en    = 1'b1;
                mem_wr.clr   = 1'b1;
                mem_wr.row   = clr_row_reg;
                clr_row_next = clr_row_reg + 1'b1;
            end
            bhta_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                rd_en     = req.valid;
            end
            bhta_pkg::ST_BUSY:
            begin
                // a probe completes once the response register is free
                done = (op_reg == bhta_pkg::OP_STORE) || !rsp_valid_reg || rsp.ready;
                if (op_reg == bhta_pkg::OP_STORE)
                begin
                    mem_wr.en        = 1'b1;
                    mem_wr.row       = row_reg;
                    mem_wr.way       = victim;
                    mem_wr.tag.tag   = tag_reg;
                    mem_wr.tag.depth = depth_reg;
                    mem_wr.tag.flag  = flag_reg;
                    mem_wr.tag.gen   = cur_gen_reg;
                    mem_wr.pay.score = score_reg;
                    mem_wr.pay.move  = move_reg;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (probe_done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bhta_pkg::ST_CLEAR;
            clr_row_reg   <= '0;
            cur_gen_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                cur_gen_reg <= cfg_wdata;
            end
        end
    end

    // request and response payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= req.op;
            row_reg      <= req.key[bhta_pkg::INDEX_BITS-1:bhta_pkg::WAY_BITS];
            home_way_reg <= req.key[bhta_pkg::WAY_BITS-1:0];
            tag_reg      <= req.key[bhta_pkg::KEY_BITS-1:bhta_pkg::TAG_SHIFT];
            score_reg    <= req.new_score;
            depth_reg    <= req.new_depth;
            flag_reg     <= req.new_flag;
            move_reg     <= req.new_move;
        end
        if (probe_done)
        begin
            rsp_res_reg <= sel_res;
        end
    end

    assign req.ready            = req_ready;
    assign rsp.valid            = rsp_valid_reg;
    assign rsp.hit              = rsp_res_reg.hit;
    assign rsp.found_score      = rsp_res_reg.score;
    assign rsp.found_depth      = rsp_res_reg.depth;
    assign rsp.found_flag       = rsp_res_reg.flag;
    assign rsp.found_generation = rsp_res_reg.gen;
    assign rsp.found_move       = rsp_res_reg.move;

    // a request is never taken in the cycle after another one was taken
    `BHTA_ASSERT_NXT(a_two_cycle_req, clk, rst_n, accept, !req.ready, "request taken back to back")
    // slot writes come only from a store in the busy stage
    `BHTA_ASSERT_IMP(a_store_write, clk, rst_n, mem_wr.en && !mem_wr.clr, (state_reg == bhta_pkg::ST_BUSY) && (op_reg == bhta_pkg::OP_STORE), "slot write outside a store")
    // a response only ever follows a finished probe
    `BHTA_ASSERT_IMP(a_rsp_from_probe, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg == bhta_pkg::ST_BUSY) && (op_reg == bhta_pkg::OP_PROBE), "response without a probe")

endmodule
